// File: rtl/mtrg_pkg.sv
// ----------------------------------------------------------------------------
// mtrg_pkg: shared types and constants
// Constants of the MT19937 core, tempering function and divider beat types.
// ----------------------------------------------------------------------------
`default_nettype none

package mtrg_pkg;

	localparam int DATA_W      = 32;
	localparam int DIV_W       = 33;
	localparam int DIV_STEPS   = 33;
	localparam int DIV_CNT_W   = 6;
	localparam int TWIST_SHIFT = 397;

	localparam logic [31:0] SEED_RESET = 32'd5489;
	localparam logic [31:0] MATRIX_A   = 32'h9908_b0df;
	localparam logic [31:0] INIT_MULT  = 32'd1812433253;
	localparam logic [31:0] TEMPER_B   = 32'h9d2c_5680;
	localparam logic [31:0] TEMPER_C   = 32'hefc6_0000;
	localparam logic [31:0] UPPER_BIT  = 32'h8000_0000;
	localparam logic [31:0] LOWER_BITS = 32'h7fff_ffff;
	localparam logic [32:0] FULL_SPAN  = 33'h1_0000_0000;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [DIV_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quot;
		logic [DIV_W-1:0] rem;
	} div_rsp_t;

	function automatic logic [31:0] temper(input logic [31:0] w);
		logic [31:0] y;
		y = w;
		y = y ^ (y >> 11);
		y = y ^ ((y << 7) & TEMPER_B);
		y = y ^ ((y << 15) & TEMPER_C);
		y = y ^ (y >> 18);
		return y;
	endfunction

endpackage

`default_nettype wire

// File: rtl/mtrg_cfg_if.sv
// ----------------------------------------------------------------------------
// mtrg_cfg_if: seed write channel
// One beat writes the seed register.
// ----------------------------------------------------------------------------
`default_nettype none

interface mtrg_cfg_if;
	logic        valid;
	logic        ready;
	logic [31:0] seed;

	modport source (output valid, output seed, input ready);
	modport sink   (input valid, input seed, output ready);
endinterface

`default_nettype wire

// File: rtl/mtrg_req_if.sv
// ----------------------------------------------------------------------------
// mtrg_req_if: request channel
// One beat carries the inclusive bounds of one draw.
// ----------------------------------------------------------------------------
`default_nettype none

interface mtrg_req_if;
	logic        valid;
	logic        ready;
	logic [31:0] range_low;
	logic [31:0] range_high;

	modport source (output valid, output range_low, output range_high, input ready);
	modport sink   (input valid, input range_low, input range_high, output ready);
endinterface

`default_nettype wire

// File: rtl/mtrg_rsp_if.sv
// ----------------------------------------------------------------------------
// mtrg_rsp_if: result channel
// One beat carries one drawn value.
// ----------------------------------------------------------------------------
`default_nettype none

interface mtrg_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

`default_nettype wire

// File: rtl/mtrg_ram.sv
// ----------------------------------------------------------------------------
// mtrg_ram: generic RAM
// One write port, two read ports, registered read data (read-first).
// ----------------------------------------------------------------------------
`default_nettype none

module mtrg_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 624
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic      [WIDTH-1:0]         rdata_a,
	output logic      [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

`default_nettype wire

// File: rtl/mtrg_div.sv
// ----------------------------------------------------------------------------
// mtrg_div: restoring divider
// One quotient bit per cycle; done pulses once the result is final.
// ----------------------------------------------------------------------------
`default_nettype none

module mtrg_div (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire mtrg_pkg::div_req_t req,
	output mtrg_pkg::div_rsp_t      rsp
);

	logic [mtrg_pkg::DIV_W-1:0]     rem_q;
	logic [mtrg_pkg::DIV_W-1:0]     quo_q;
	logic [mtrg_pkg::DIV_W-1:0]     dvs_q;
	logic [mtrg_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                           busy_q;
	logic                           done_q;

	logic [mtrg_pkg::DIV_W:0]   shifted;
	logic [mtrg_pkg::DIV_W+1:0] diff;
	logic                       fits;

	always_comb begin
		shifted = {rem_q, quo_q[mtrg_pkg::DIV_W-1]};
		diff    = {1'b0, shifted} - {2'b00, dvs_q};
		fits    = !diff[mtrg_pkg::DIV_W+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			quo_q  <= '0;
			dvs_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= mtrg_pkg::DIV_CNT_W'(mtrg_pkg::DIV_STEPS);
				rem_q  <= '0;
				quo_q  <= req.dividend;
				dvs_q  <= req.divisor;
			end else if (busy_q) begin
				rem_q <= fits ? diff[mtrg_pkg::DIV_W-1:0] : shifted[mtrg_pkg::DIV_W-1:0];
				quo_q <= {quo_q[mtrg_pkg::DIV_W-2:0], fits};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == mtrg_pkg::DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quo_q;
	assign rsp.rem  = rem_q;

endmodule

`default_nettype wire

// File: rtl/mersenne_twister_range_generator.sv
// ----------------------------------------------------------------------------
// mersenne_twister_range_generator: MT19937 with range reduction
// Sequencer around the state RAM and a shared bit-serial divider.
// ----------------------------------------------------------------------------
// A result becomes valid once the 33-step divider has produced its quotient.
// A span differing from the cached one also needs the bucket division.
// Each rejected word adds another read; every 624th word adds a twist pass.
// Requests are taken one at a time; the next is taken while a result waits.
// After reset or a seed write the state fill runs with req not ready.
`default_nettype none

module mersenne_twister_range_generator #(
	parameter int STATE_WORDS = 624
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	mtrg_cfg_if.sink     cfg,
	mtrg_req_if.sink     req,
	mtrg_rsp_if.source   rsp
);

	localparam int AW = $clog2(STATE_WORDS);
	localparam int PW = $clog2(STATE_WORDS + 1);

	typedef enum logic [3:0] {
		S_FILL_W0,
		S_FILL_MUL,
		S_FILL_ADD,
		S_IDLE,
		S_BKT,
		S_DRAW,
		S_RD_WAIT,
		S_CHECK,
		S_QDIV,
		S_OUT,
		S_TW_PRE,
		S_TW_LD,
		S_TW_RD,
		S_TW_WR
	} state_t;

	state_t      st_q;
	logic [31:0] seed_q;
	logic [PW-1:0] pos_q;
	logic [AW-1:0] k_q;
	logic [31:0] p_q;
	logic [31:0] mul_q;
	logic [31:0] cur_q;
	logic [31:0] lo_q;
	logic [31:0] span_q;
	logic [31:0] cspan_q;
	logic        cvld_q;
	logic [mtrg_pkg::DIV_W-1:0] bkt_q;
	logic [31:0] rem_q;
	logic [31:0] r_q;
	logic [31:0] quo_q;
	logic [31:0] value_q;
	logic        out_vld_q;

	logic                 ram_we;
	logic [AW-1:0]        ram_waddr;
	logic [31:0]          ram_wdata;
	logic [AW-1:0]        ram_raddr_a;
	logic [AW-1:0]        ram_raddr_b;
	logic [31:0]          ram_rdata_a;
	logic [31:0]          ram_rdata_b;

	mtrg_pkg::div_req_t div_req;
	mtrg_pkg::div_rsp_t div_rsp;

	logic [31:0] span_in;
	logic [31:0] mix;
	logic [31:0] mul_lo;
	logic [31:0] fill_word;
	logic [AW:0] far_sum;
	logic [AW-1:0] far_idx;
	logic [AW-1:0] nxt_idx;
	logic [31:0] tw_y;
	logic [31:0] tw_word;
	logic [32:0] rej_sum;
	logic        req_beat;
	logic        cfg_beat;
	logic        out_free;

	assign cfg.ready = (st_q == S_IDLE);
	assign req.ready = (st_q == S_IDLE) && !cfg.valid;
	assign cfg_beat  = cfg.valid && cfg.ready;
	assign req_beat  = req.valid && req.ready;
	assign rsp.valid = out_vld_q;
	assign rsp.value = value_q;
	assign out_free  = !out_vld_q || rsp.ready;

	always_comb begin
		span_in   = req.range_high - req.range_low + 32'd1;
		mix       = p_q ^ (p_q >> 30);
		mul_lo    = mix * mtrg_pkg::INIT_MULT;
		fill_word = mul_q + {{(32-AW){1'b0}}, k_q};
		far_sum   = {1'b0, k_q} + (AW+1)'(mtrg_pkg::TWIST_SHIFT);
		if (far_sum >= (AW+1)'(STATE_WORDS)) begin
			far_idx = AW'(far_sum - (AW+1)'(STATE_WORDS));
		end else begin
			far_idx = far_sum[AW-1:0];
		end
		nxt_idx = (k_q == AW'(STATE_WORDS - 1)) ? '0 : k_q + 1'b1;
		tw_y    = (cur_q & mtrg_pkg::UPPER_BIT) | (ram_rdata_a & mtrg_pkg::LOWER_BITS);
		tw_word = ram_rdata_b ^ (tw_y >> 1) ^ (tw_y[0] ? mtrg_pkg::MATRIX_A : 32'd0);
		rej_sum = {1'b0, r_q} + {1'b0, rem_q};
	end

	always_comb begin
		ram_we      = 1'b0;
		ram_waddr   = k_q;
		ram_wdata   = fill_word;
		ram_raddr_a = '0;
		ram_raddr_b = far_idx;
		unique case (st_q)
			S_FILL_W0: begin
				ram_we    = 1'b1;
				ram_waddr = '0;
				ram_wdata = seed_q;
			end
			S_FILL_ADD: begin
				ram_we = 1'b1;
			end
			S_DRAW: begin
				ram_raddr_a = pos_q[AW-1:0];
			end
			S_TW_RD: begin
				ram_raddr_a = nxt_idx;
			end
			S_TW_WR: begin
				ram_we    = 1'b1;
				ram_wdata = tw_word;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		div_req.start    = 1'b0;
		div_req.dividend = mtrg_pkg::FULL_SPAN;
		div_req.divisor  = {1'b0, span_in};
		if (req_beat && span_in != 32'd0 && !(cvld_q && cspan_q == span_in)) begin
			div_req.start = 1'b1;
		end else if (st_q == S_CHECK && !rej_sum[32]) begin
			div_req.start    = 1'b1;
			div_req.dividend = {1'b0, r_q};
			div_req.divisor  = bkt_q;
		end
	end

	mtrg_ram #(
		.WIDTH (32),
		.DEPTH (STATE_WORDS)
	) u_ram (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (ram_waddr),
		.wdata   (ram_wdata),
		.raddr_a (ram_raddr_a),
		.raddr_b (ram_raddr_b),
		.rdata_a (ram_rdata_a),
		.rdata_b (ram_rdata_b)
	);

	mtrg_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= S_FILL_W0;
			seed_q    <= mtrg_pkg::SEED_RESET;
			pos_q     <= PW'(STATE_WORDS);
			k_q       <= '0;
			p_q       <= '0;
			mul_q     <= '0;
			cur_q     <= '0;
			lo_q      <= '0;
			span_q    <= '0;
			cspan_q   <= '0;
			cvld_q    <= 1'b0;
			bkt_q     <= '0;
			rem_q     <= '0;
			r_q       <= '0;
			quo_q     <= '0;
			value_q   <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (st_q == S_OUT && out_free) begin
				out_vld_q <= 1'b1;
			end else if (out_vld_q && rsp.ready) begin
				out_vld_q <= 1'b0;
			end
			unique case (st_q)
				S_FILL_W0: begin
					p_q  <= seed_q;
					k_q  <= AW'(1);
					st_q <= S_FILL_MUL;
				end
				S_FILL_MUL: begin
					mul_q <= mul_lo;
					st_q  <= S_FILL_ADD;
				end
				S_FILL_ADD: begin
					p_q <= fill_word;
					if (k_q == AW'(STATE_WORDS - 1)) begin
						pos_q <= PW'(STATE_WORDS);
						st_q  <= S_IDLE;
					end else begin
						k_q  <= k_q + 1'b1;
						st_q <= S_FILL_MUL;
					end
				end
				S_IDLE: begin
					if (cfg_beat) begin
						seed_q <= cfg.seed;
						st_q   <= S_FILL_W0;
					end else if (req_beat) begin
						lo_q   <= req.range_low;
						span_q <= span_in;
						if (span_in == 32'd0) begin
							// full range: one word per value, nothing rejected
							bkt_q  <= mtrg_pkg::DIV_W'(1);
							rem_q  <= '0;
							cvld_q <= 1'b0;
							st_q   <= S_DRAW;
						end else if (cvld_q && cspan_q == span_in) begin
							st_q <= S_DRAW;
						end else begin
							st_q <= S_BKT;
						end
					end
				end
				S_BKT: begin
					if (div_rsp.done) begin
						bkt_q   <= div_rsp.quot;
						rem_q   <= div_rsp.rem[31:0];
						cspan_q <= span_q;
						cvld_q  <= 1'b1;
						st_q    <= S_DRAW;
					end
				end
				S_DRAW: begin
					if (pos_q == PW'(STATE_WORDS)) begin
						k_q  <= '0;
						st_q <= S_TW_PRE;
					end else begin
						st_q <= S_RD_WAIT;
					end
				end
				S_RD_WAIT: begin
					r_q   <= mtrg_pkg::temper(ram_rdata_a);
					pos_q <= pos_q + 1'b1;
					st_q  <= S_CHECK;
				end
				S_CHECK: begin
					// word + (2^32 mod span) carrying out means word >= accept limit
					st_q <= rej_sum[32] ? S_DRAW : S_QDIV;
				end
				S_QDIV: begin
					if (div_rsp.done) begin
						quo_q <= div_rsp.quot[31:0];
						st_q  <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						value_q <= lo_q + quo_q;
						st_q    <= S_IDLE;
					end
				end
				S_TW_PRE: begin
					st_q <= S_TW_LD;
				end
				S_TW_LD: begin
					cur_q <= ram_rdata_a;
					st_q  <= S_TW_RD;
				end
				S_TW_RD: begin
					st_q <= S_TW_WR;
				end
				S_TW_WR: begin
					cur_q <= ram_rdata_a;
					if (k_q == AW'(STATE_WORDS - 1)) begin
						pos_q <= '0;
						st_q  <= S_DRAW;
					end else begin
						k_q  <= k_q + 1'b1;
						st_q <= S_TW_RD;
					end
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// File: rtl/mtrg_checker.sv
// ----------------------------------------------------------------------------
// mtrg_checker: port-level checks
// Watches the channels of the generator over time; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mtrg_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        cfg_valid,
	input wire logic        cfg_ready,
	input wire logic        req_valid,
	input wire logic        req_ready,
	input wire logic        rsp_valid,
	input wire logic        rsp_ready,
	input wire logic [31:0] rsp_value
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result beat dropped while stalled");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp_value))
		else $error("result value changed while stalled");

	a_req_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while previous one in progress");

	a_cfg_refill: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |=> !req_ready && !cfg_ready)
		else $error("ready during state refill");

	a_no_instant_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> !$past(req_valid && req_ready))
		else $error("result appeared straight after request beat");

endmodule

bind mersenne_twister_range_generator mtrg_checker u_mtrg_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cfg_valid (cfg.valid),
	.cfg_ready (cfg.ready),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_value (rsp.value)
);

`default_nettype wire

// File: tb/mtrg_draw_check.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mtrg_draw_check: draw predictor and result checker
// Watches the seed, request and result channels. It keeps its own copy of the
// MT19937 state and the seed, predicts the ranged value for every request beat,
// and compares each result beat against the oldest prediction.
// ----------------------------------------------------------------------------

module mtrg_draw_check #(
	parameter int STATE_WORDS = 624
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [31:0] cfg_seed,
	input  logic        req_valid,
	input  logic        req_ready,
	input  logic [31:0] range_low,
	input  logic [31:0] range_high,
	input  logic        rsp_valid,
	input  logic        rsp_ready,
	input  logic [31:0] value,
	output int          fail_count,
	output int          pending,
	output int          draws_checked
);

	localparam int          MAX_REPORTS = 20;
	localparam int          FAR_OFFSET  = 397;
	localparam logic [31:0] SEED_AT_RST = 32'd5489;
	localparam logic [31:0] TWIST_XOR   = 32'h9908_b0df;
	localparam logic [31:0] FILL_MULT   = 32'd1812433253;
	localparam logic [31:0] MASK_B      = 32'h9d2c_5680;
	localparam logic [31:0] MASK_C      = 32'hefc6_0000;
	localparam logic [31:0] TOP_BIT     = 32'h8000_0000;
	localparam logic [31:0] LOW_BITS    = 32'h7fff_ffff;
	localparam logic [63:0] WORD_SPACE  = 64'h1_0000_0000;

	logic [31:0] seed_word;
	logic [31:0] mt_words [0:STATE_WORDS-1];
	int unsigned mt_pos;
	logic [31:0] expected_draws [$];
	logic [31:0] due_value;

	initial begin
		fail_count    = 0;
		pending       = 0;
		draws_checked = 0;
	end

	function automatic void fill_words();
		logic [31:0] p;
		mt_words[0] = seed_word;
		for (int k = 1; k < STATE_WORDS; k++) begin
			p           = mt_words[k-1];
			mt_words[k] = FILL_MULT * (p ^ (p >> 30)) + 32'(k);
		end
		mt_pos = STATE_WORDS;
	endfunction

	function automatic void twist_words();
		logic [31:0] y;
		for (int k = 0; k < STATE_WORDS; k++) begin
			y = (mt_words[k] & TOP_BIT) | (mt_words[(k + 1) % STATE_WORDS] & LOW_BITS);
			mt_words[k] = mt_words[(k + FAR_OFFSET) % STATE_WORDS] ^ (y >> 1)
				^ (y[0] ? TWIST_XOR : 32'd0);
		end
		mt_pos = 0;
	endfunction

	function automatic logic [31:0] next_tempered();
		logic [31:0] y;
		if (mt_pos >= STATE_WORDS)
			twist_words();
		y      = mt_words[mt_pos];
		mt_pos = mt_pos + 1;
		y      = y ^ (y >> 11);
		y      = y ^ ((y << 7) & MASK_B);
		y      = y ^ ((y << 15) & MASK_C);
		y      = y ^ (y >> 18);
		return y;
	endfunction

	// span of zero stands for all 2^32 values
	function automatic logic [31:0] predict_draw(input logic [31:0] lo, input logic [31:0] hi);
		logic [31:0] span32;
		logic [63:0] span;
		logic [63:0] bucket;
		logic [63:0] accept_below;
		logic [63:0] w;
		span32       = hi - lo + 32'd1;
		span         = (span32 == 32'd0) ? WORD_SPACE : {32'd0, span32};
		bucket       = WORD_SPACE / span;
		accept_below = bucket * span;
		do
			w = {32'd0, next_tempered()};
		while (w >= accept_below);
		return lo + 32'(w / bucket);
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			seed_word = SEED_AT_RST;
			fill_words();
			expected_draws.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				seed_word = cfg_seed;
				fill_words();
			end
			if (rsp_valid && rsp_ready) begin
				if (expected_draws.size() == 0) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS)
						$display("%0t: unexpected result beat, expected none, actual %h",
							$time, value);
				end else begin
					due_value = expected_draws.pop_front();
					draws_checked++;
					if (value !== due_value) begin
						fail_count++;
						if (fail_count <= MAX_REPORTS)
							$display("%0t: value mismatch, expected %h, actual %h",
								$time, due_value, value);
					end
				end
			end
			if (req_valid && req_ready)
				expected_draws.push_back(predict_draw(range_low, range_high));
		end
		pending = expected_draws.size();
	end

endmodule

// File: tb/mersenne_twister_range_generator_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mersenne_twister_range_generator_tb: ranged MT19937 generator test
// Drives directed and random range requests under several seeds and idle
// mixes, including a long result hold-off, and reports the checker's verdict.
// ----------------------------------------------------------------------------

module mersenne_twister_range_generator_tb;

	localparam int          RESET_CYCLES   = 8;
	localparam int          DRAIN_CYCLES   = 64;
	localparam int          HOLD_CYCLES    = 400;
	localparam int          WATCHDOG_LIMIT = 20000;
	localparam logic [31:0] SEED_DEFAULT   = 32'd5489;

	typedef enum int {
		RK_FULL,
		RK_SINGLE,
		RK_NARROW,
		RK_HALF,
		RK_POW2,
		RK_REPEAT,
		RK_ANY,
		RK_WIDE
	} range_kind_t;

	logic        clk;
	logic        arst_n;
	int          fail_count;
	int          pending;
	int          draws_checked;
	int          send_idle_pct;
	int          recv_idle_pct;
	logic        hold_trigger;
	logic        hold_seen;
	int          hold_left;
	int          idle_cycles;
	int          requests_sent;
	int          seeds_written;
	logic [31:0] prev_lo;
	logic [31:0] prev_hi;

	mtrg_cfg_if cfg ();
	mtrg_req_if req ();
	mtrg_rsp_if rsp ();

	mersenne_twister_range_generator u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.req    (req),
		.rsp    (rsp)
	);

	mtrg_draw_check u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg.valid),
		.cfg_ready     (cfg.ready),
		.cfg_seed      (cfg.seed),
		.req_valid     (req.valid),
		.req_ready     (req.ready),
		.range_low     (req.range_low),
		.range_high    (req.range_high),
		.rsp_valid     (rsp.valid),
		.rsp_ready     (rsp.ready),
		.value         (rsp.value),
		.fail_count    (fail_count),
		.pending       (pending),
		.draws_checked (draws_checked)
	);

	initial begin
		clk            = 1'b0;
		arst_n         = 1'b0;
		cfg.valid      = 1'b0;
		cfg.seed       = 32'd0;
		req.valid      = 1'b0;
		req.range_low  = 32'd0;
		req.range_high = 32'd0;
		rsp.ready      = 1'b0;
		hold_trigger   = 1'b0;
		hold_seen      = 1'b0;
		hold_left      = 0;
		idle_cycles    = 0;
		send_idle_pct  = 0;
		recv_idle_pct  = 0;
		requests_sent  = 0;
		seeds_written  = 0;
		prev_lo        = 32'd0;
		prev_hi        = 32'd0;
	end

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// receiver: random idling, plus a long hold-off on each toggle of hold_trigger
	always @(posedge clk) begin
		if (hold_trigger != hold_seen) begin
			hold_seen <= hold_trigger;
			hold_left <= HOLD_CYCLES;
			rsp.ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			rsp.ready <= 1'b0;
		end else begin
			rsp.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("timeout: no beat for %0d cycles", WATCHDOG_LIMIT);
			$display("end of test: mismatches");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic send_range(input logic [31:0] lo, input logic [31:0] hi);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid      <= 1'b1;
		req.range_low  <= lo;
		req.range_high <= hi;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		requests_sent++;
	endtask

	task automatic settle();
		req.valid <= 1'b0;
		do
			@(negedge clk);
		while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_seed(input logic [31:0] s);
		settle();
		cfg.valid <= 1'b1;
		cfg.seed  <= s;
		@(posedge clk);
		while (!cfg.ready)
			@(posedge clk);
		cfg.valid <= 1'b0;
		seeds_written++;
	endtask

	task automatic set_idle(input int send_pct, input int recv_pct);
		send_idle_pct  = send_pct;
		recv_idle_pct <= recv_pct;
	endtask

	task automatic pick_range(output logic [31:0] lo, output logic [31:0] hi);
		range_kind_t kind;
		logic [31:0] a;
		int          sh;
		kind = range_kind_t'($urandom_range(0, 7));
		a    = $urandom;
		lo   = a;
		case (kind)
			RK_FULL:   hi = a - 32'd1;
			RK_SINGLE: hi = a;
			RK_NARROW: hi = a + $urandom_range(1, 63);
			RK_HALF:   hi = a + 32'h7fff_ffff + $urandom_range(0, 3);
			RK_POW2: begin
				sh = $urandom_range(1, 31);
				hi = a + (32'd1 << sh) - 32'd1;
			end
			RK_REPEAT: begin
				lo = prev_lo + $urandom_range(0, 1000);
				hi = lo + (prev_hi - prev_lo);
			end
			default:   hi = $urandom;
		endcase
		prev_lo = lo;
		prev_hi = hi;
	endtask

	task automatic run_random(input int n);
		logic [31:0] lo;
		logic [31:0] hi;
		for (int i = 0; i < n; i++) begin
			pick_range(lo, hi);
			send_range(lo, hi);
		end
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// directed: bound extremes, wrapped spans, rejection-heavy spans
		set_idle(18, 81);
		send_range(32'h0000_0000, 32'hffff_ffff);
		send_range(32'h0000_0005, 32'h0000_0004);
		send_range(32'h0000_0000, 32'h0000_0000);
		send_range(32'hffff_ffff, 32'hffff_ffff);
		send_range(32'h0000_0000, 32'h0000_0001);
		send_range(32'hffff_fffe, 32'hffff_ffff);
		send_range(32'h0000_0000, 32'h7fff_ffff);
		send_range(32'h0000_0000, 32'h8000_0000);
		send_range(32'h0000_0000, 32'h8000_0000);
		send_range(32'h8000_0000, 32'h7fff_fffe);
		send_range(32'h0000_0000, 32'hffff_fffe);
		send_range(32'hffff_fff0, 32'h0000_000f);
		send_range(32'h0000_000a, 32'h0000_0003);
		send_range(32'h0000_0064, 32'h0000_00c7);
		send_range(32'h0000_0064, 32'h0000_00c7);
		send_range(32'h5555_5555, 32'haaaa_aaaa);
		send_range(32'haaaa_aaaa, 32'h5555_5555);
		send_range(32'hffff_ffff, 32'h0000_0000);
		send_range(32'h0000_0001, 32'h0000_0000);
		send_range(32'h0000_0000, 32'h0000_0002);
		send_range(32'h0000_0000, 32'h5555_5555);
		send_range(32'h8000_0000, 32'hffff_ffff);

		write_seed(32'h0000_0000);
		run_random(150);
		hold_trigger <= ~hold_trigger;
		run_random(150);

		write_seed(32'hffff_ffff);
		set_idle(81, 18);
		run_random(300);

		write_seed($urandom);
		set_idle(0, 0);
		run_random(150);
		hold_trigger <= ~hold_trigger;
		run_random(150);

		write_seed(SEED_DEFAULT);
		run_random(130);

		settle();
		$display("covered %0d range requests over %0d seed writes, %0d values compared",
			requests_sent, seeds_written, draws_checked);
		$display("idle mixes: sender-light, receiver-light, back-to-back, two result hold-offs");
		if (fail_count == 0 && pending == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

// File: filelist.f
rtl/mtrg_pkg.sv
rtl/mtrg_cfg_if.sv
rtl/mtrg_req_if.sv
rtl/mtrg_rsp_if.sv
rtl/mtrg_ram.sv
rtl/mtrg_div.sv
rtl/mersenne_twister_range_generator.sv
rtl/mtrg_checker.sv
tb/mtrg_draw_check.sv
tb/mersenne_twister_range_generator_tb.sv
